// ----- rtl/ptor_pkg.sv -----
`default_nettype none
package ptor_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int MAC_W   = 48;
   localparam int KIND_W  = 2;
   localparam int IDENT_W = 32;
   localparam int CHAN_W  = 4;
   localparam int TIME_W  = 48;
   localparam int CMD_W   = 2;
   localparam int OUT_W   = 3;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 4;

   localparam logic [CMD_W-1:0] CMD_LEARN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [OUT_W-1:0] OUT_SAME     = 3'd0;
   localparam logic [OUT_W-1:0] OUT_CHANGED  = 3'd1;
   localparam logic [OUT_W-1:0] OUT_APPENDED = 3'd2;
   localparam logic [OUT_W-1:0] OUT_REPLACED = 3'd3;
   localparam logic [OUT_W-1:0] OUT_REMOVED  = 3'd4;
   localparam logic [OUT_W-1:0] OUT_RM_MISS  = 3'd5;
   localparam logic [OUT_W-1:0] OUT_KNOWN    = 3'd6;
   localparam logic [OUT_W-1:0] OUT_UNKNOWN  = 3'd7;

   typedef struct packed {
      logic [MAC_W-1:0]   mac;
      logic               role;
      logic [KIND_W-1:0]  kind;
      logic [IDENT_W-1:0] ident;
      logic [CHAN_W-1:0]  chan;
      logic [TIME_W-1:0]  seen;
   } entry_type;

   typedef struct packed {
      logic mac_hit;
      logic query_hit;
      logic older;
      logic changed;
   } match_type;

endpackage
`default_nettype wire

// ----- rtl/ptor_entry_ram.sv -----
`default_nettype none
module ptor_entry_ram (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [ptor_pkg::IDX_W-1:0] wr_addr,
   input  wire ptor_pkg::entry_type     wr_data,
   input  wire logic                    rd_en,
   input  wire logic [ptor_pkg::IDX_W-1:0] rd_addr,
   output ptor_pkg::entry_type          rd_data
);
   import ptor_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/ptor_match_unit.sv -----
`default_nettype none
module ptor_match_unit (
   input  wire ptor_pkg::entry_type          stored,
   input  wire ptor_pkg::entry_type          request,
   input  wire logic [ptor_pkg::TIME_W-1:0]  best_seen,
   output ptor_pkg::match_type               result,
   output ptor_pkg::entry_type               merged
);
   import ptor_pkg::*;

   logic ident_given;

   assign ident_given = (request.ident != '0);

   always_comb begin
      result.mac_hit   = (stored.mac == request.mac);
      result.query_hit = result.mac_hit || (ident_given && (stored.ident == request.ident));
      result.older     = (stored.seen < best_seen);
      // time alone does not count as a change
      result.changed   = (stored.role != request.role) || (stored.kind != request.kind) ||
                         (ident_given && (stored.ident != request.ident)) ||
                         (stored.chan != request.chan);
      merged           = request;
      merged.ident     = ident_given ? request.ident : stored.ident;
   end

endmodule
`default_nettype wire

// ----- rtl/peer_table_oldest_replace_unit.sv -----
`default_nettype none
// Peer table of TABLE_DEPTH entries kept packed at the front of a small
// single-port-read memory. Each learn, remove or query walks the valid entries
// one at a time through one shared compare unit (registered memory read, then
// compare), and stops at the first hit. A learn on a full table with no
// hit scans all entries and replaces the oldest; a remove that moves the last
// entry into the hole adds a read of the last entry and a write into the hole.
// An empty table skips the scan. One command is in work at a time; the next beat
// is taken while a finished response still waits on the response port.
module peer_table_oldest_replace_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [ptor_pkg::CMD_W-1:0]   req_command,
   input  wire logic [ptor_pkg::MAC_W-1:0]   req_peer_mac,
   input  wire logic                        req_peer_role,
   input  wire logic [ptor_pkg::KIND_W-1:0]  req_peer_kind,
   input  wire logic [ptor_pkg::IDENT_W-1:0] req_peer_ident,
   input  wire logic [ptor_pkg::CHAN_W-1:0]  req_radio_channel,
   input  wire logic [ptor_pkg::TIME_W-1:0]  req_now_time,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [ptor_pkg::OUT_W-1:0]       rsp_outcome,
   output logic [ptor_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [ptor_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic                             rsp_save_request
);
   import ptor_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_MREAD  = 3'd3;
   localparam logic [2:0] S_MWRITE = 3'd4;
   localparam logic [2:0] S_MISS   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_seen_ff, best_seen_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   entry_type         req_ff, req_in;
   logic [OUT_W-1:0]  res_outcome_ff, res_outcome_in;
   logic [IDX_W-1:0]  res_slot_ff, res_slot_in;
   logic              res_save_ff, res_save_in;

   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_outcome_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_save_ff;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data, merged;
   match_type         match;
   logic [IDX_W-1:0]  last_idx;
   logic              table_full, hit, rsp_free;

   ptor_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptor_match_unit u_match (
      .stored    (rd_data),
      .request   (req_ff),
      .best_seen (best_seen_ff),
      .result    (match),
      .merged    (merged)
   );

   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign hit        = (cmd_ff == CMD_QUERY) ? match.query_hit : match.mac_hit;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      best_idx_in    = best_idx_ff;
      best_seen_in   = best_seen_ff;
      cmd_in         = cmd_ff;
      req_in         = req_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      res_save_in    = res_save_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = merged;
      rd_en          = 1'b0;
      rd_addr        = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_command;
               req_in.mac     = req_peer_mac;
               req_in.role    = req_peer_role;
               req_in.kind    = req_peer_kind;
               req_in.ident   = req_peer_ident;
               req_in.chan    = req_radio_channel;
               req_in.seen    = req_now_time;
               idx_in         = '0;
               res_outcome_in = OUT_UNKNOWN;
               res_slot_in    = '0;
               res_save_in    = 1'b0;
               if (req_command != CMD_LEARN && req_command != CMD_REMOVE &&
                   req_command != CMD_QUERY) begin
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            // first minimum: only a strictly older entry takes over
            if (match.older || idx_ff == '0) begin
               best_idx_in  = idx_ff;
               best_seen_in = rd_data.seen;
            end
            if (hit) begin
               res_slot_in = idx_ff;
               state_in    = S_DONE;
               unique case (cmd_ff)
                  CMD_LEARN: begin
                     wr_en          = 1'b1;
                     res_outcome_in = match.changed ? OUT_CHANGED : OUT_SAME;
                     res_save_in    = match.changed;
                  end
                  CMD_REMOVE: begin
                     res_outcome_in = OUT_REMOVED;
                     res_save_in    = 1'b1;
                     if (idx_ff == last_idx) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        state_in = S_MREAD;
                     end
                  end
                  default: begin
                     res_outcome_in = OUT_KNOWN;
                  end
               endcase
            end else if (idx_ff == last_idx) begin
               state_in = S_MISS;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_MREAD: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            state_in = S_MWRITE;
         end
         S_MWRITE: begin
            // last entry fills the hole
            wr_en    = 1'b1;
            wr_data  = rd_data;
            count_in = count_ff - CNT_W'(1);
            state_in = S_DONE;
         end
         S_MISS: begin
            state_in    = S_DONE;
            res_slot_in = '0;
            res_save_in = 1'b0;
            unique case (cmd_ff)
               CMD_LEARN: begin
                  wr_en   = 1'b1;
                  wr_data = req_ff;
                  if (table_full) begin
                     wr_addr        = best_idx_ff;
                     res_outcome_in = OUT_REPLACED;
                     res_slot_in    = best_idx_ff;
                  end else begin
                     wr_addr        = IDX_W'(count_ff);
                     count_in       = count_ff + CNT_W'(1);
                     res_outcome_in = OUT_APPENDED;
                     res_slot_in    = IDX_W'(count_ff);
                     res_save_in    = 1'b1;
                  end
               end
               CMD_REMOVE: res_outcome_in = OUT_RM_MISS;
               default:    res_outcome_in = OUT_UNKNOWN;
            endcase
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      best_idx_ff    <= best_idx_in;
      best_seen_ff   <= best_seen_in;
      cmd_ff         <= cmd_in;
      req_ff         <= req_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      res_save_ff    <= res_save_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_outcome_ff <= res_outcome_ff;
         rsp_slot_ff    <= SLOT_W'(res_slot_ff);
         rsp_count_ff   <= COUNT_W'(count_ff);
         rsp_save_ff    <= res_save_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_save_request = rsp_save_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE || state_ff == S_READ) |-> !wr_en)
      else $error("table written outside an update step");

   a_count_source: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_CMP || $past(state_ff) == S_MISS ||
          $past(state_ff) == S_MWRITE))
      else $error("entry count changed outside an update step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised without a finished command");

endmodule
`default_nettype wire
